@@ design/fbc_pkg.sv @@
`timescale 1ns / 1ps
package fbc_pkg;

   // Plane normal component, Q16
   localparam int NW = 27;

   typedef logic signed [NW-1:0] nrm_type;
   typedef nrm_type [2:0]         vec_type;
   typedef vec_type [5:0]         planes_type;

   // Quarter-wave sine polynomial coefficients, Q16
   localparam logic [16:0] SIN_A = 17'd102944;
   localparam logic [16:0] SIN_B = 17'd42048;
   localparam logic [16:0] SIN_C = 17'd4640;

   localparam int DIV_STEPS = 40;
   localparam int MUL_STEPS = 9;

   // Register indexes
   localparam logic [2:0] REG_CAM_X  = 3'd0;
   localparam logic [2:0] REG_CAM_Y  = 3'd1;
   localparam logic [2:0] REG_CAM_Z  = 3'd2;
   localparam logic [2:0] REG_YAW    = 3'd3;
   localparam logic [2:0] REG_PITCH  = 3'd4;
   localparam logic [2:0] REG_ASPECT = 3'd5;
   localparam logic [2:0] REG_FOCAL  = 3'd6;

   typedef enum logic [3:0] {
      SU_IDLE,
      SU_SIN_U,
      SU_SIN_U2,
      SU_SIN_R1,
      SU_SIN_R2,
      SU_SIN_S,
      SU_DIV,
      SU_MUL,
      SU_NORM
   } setup_state_type;

   typedef struct packed {
      logic [15:0] yaw;
      logic [15:0] pitch;
      logic [23:0] aspect;
      logic [23:0] focal;
   } setup_cfg_type;

endpackage

@@ design/fbc_setup.sv @@
`timescale 1ns / 1ps
module fbc_setup import fbc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          kick,
   input  setup_cfg_type cfg,
   output logic          busy,
   output planes_type    planes
);

   setup_state_type state_ff, state_in;
   logic [1:0]  ang_ff;
   logic [5:0]  cnt_ff;
   logic [16:0] u_ff, u2_ff, r_ff;
   logic        neg_ff;
   logic signed [17:0] sin_ff [4];
   logic [39:0] quo_ff;
   logic [23:0] rem_ff;
   logic signed [18:0] up0_ff, up2_ff, fw0_ff, fw2_ff;
   logic signed [25:0] rr0_ff, rr2_ff, uu0_ff, uu1_ff, uu2_ff;
   planes_type planes_ff;

   logic [15:0] base, ang_val;
   logic [14:0] qt;
   logic [16:0] u_in;
   logic [23:0] dvs, ratio;
   logic [24:0] rem_sh;
   logic        ge;
   logic [23:0] rem_in;
   logic signed [25:0] ma, mb;
   logic signed [51:0] mp;
   logic signed [35:0] mq;
   logic signed [17:0] s_mag;
   vec_type fw, rr, uu;

   // sine angle: cos taken as sine a quarter turn ahead
   assign base    = ang_ff[1] ? cfg.pitch : cfg.yaw;
   assign ang_val = ang_ff[0] ? base : base + 16'd16384;
   assign qt      = ang_val[14] ? 15'd16384 - {1'b0, ang_val[13:0]} : {1'b0, ang_val[13:0]};
   assign u_in    = {qt, 2'b00};

   // restoring divider for focal / aspect
   assign dvs    = (cfg.aspect == 24'd0) ? 24'd1 : cfg.aspect;
   assign rem_sh = {rem_ff, quo_ff[39]};
   assign ge     = rem_sh >= {1'b0, dvs};
   assign rem_in = ge ? 24'(rem_sh - {1'b0, dvs}) : rem_sh[23:0];
   assign ratio  = (|quo_ff[39:24]) ? 24'hFFFFFF : quo_ff[23:0];

   assign mp    = 52'(ma) * 52'(mb);
   assign mq    = mp[51:16];
   assign s_mag = 18'($signed({1'b0, mq[16:0]}));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SU_IDLE:   if (kick) state_in = SU_SIN_U;
         SU_SIN_U:  state_in = SU_SIN_U2;
         SU_SIN_U2: state_in = SU_SIN_R1;
         SU_SIN_R1: state_in = SU_SIN_R2;
         SU_SIN_R2: state_in = SU_SIN_S;
         SU_SIN_S:  state_in = (ang_ff == 2'd3) ? SU_DIV : SU_SIN_U;
         SU_DIV:    if (cnt_ff == 6'(DIV_STEPS - 1)) state_in = SU_MUL;
         SU_MUL:    if (cnt_ff == 6'(MUL_STEPS - 1)) state_in = SU_NORM;
         SU_NORM:   state_in = SU_IDLE;
         default:   state_in = SU_IDLE;
      endcase
   end

   always_comb begin
      busy = (state_ff != SU_IDLE);
      ma   = '0;
      mb   = '0;
      unique case (state_ff)
         SU_SIN_U2: begin
            ma = $signed({9'd0, u_ff});
            mb = $signed({9'd0, u_ff});
         end
         SU_SIN_R1: begin
            ma = $signed({9'd0, SIN_C});
            mb = $signed({9'd0, u2_ff});
         end
         SU_SIN_R2: begin
            ma = $signed({9'd0, r_ff});
            mb = $signed({9'd0, u2_ff});
         end
         SU_SIN_S: begin
            ma = $signed({9'd0, r_ff});
            mb = $signed({9'd0, u_ff});
         end
         SU_MUL: begin
            unique case (cnt_ff[3:0])
               4'd0: begin ma = 26'(sin_ff[1]); mb = 26'(sin_ff[3]); end
               4'd1: begin ma = 26'(sin_ff[0]); mb = 26'(sin_ff[3]); end
               4'd2: begin ma = 26'(sin_ff[1]); mb = 26'(sin_ff[2]); end
               4'd3: begin ma = 26'(sin_ff[0]); mb = 26'(sin_ff[2]); end
               4'd4: begin ma = 26'(sin_ff[0]); mb = $signed({2'b00, ratio}); end
               4'd5: begin ma = 26'(sin_ff[1]); mb = $signed({2'b00, ratio}); end
               4'd6: begin ma = 26'(up0_ff); mb = $signed({2'b00, cfg.focal}); end
               4'd7: begin ma = 26'(sin_ff[2]); mb = $signed({2'b00, cfg.focal}); end
               4'd8: begin ma = 26'(up2_ff); mb = $signed({2'b00, cfg.focal}); end
               default: begin ma = '0; mb = '0; end
            endcase
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SU_SIN_U;
         ang_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == SU_SIN_S) ang_ff <= ang_ff + 2'd1;
         else if (state_ff == SU_IDLE) ang_ff <= '0;
         if (state_ff == SU_DIV || state_ff == SU_MUL) begin
            cnt_ff <= (state_in != state_ff) ? 6'd0 : cnt_ff + 6'd1;
         end else begin
            cnt_ff <= '0;
         end
      end
   end

   always_comb begin
      fw[0] = NW'(fw0_ff);
      fw[1] = NW'(sin_ff[3]);
      fw[2] = NW'(fw2_ff);
      rr[0] = NW'(rr0_ff);
      rr[1] = '0;
      rr[2] = NW'(rr2_ff);
      uu[0] = NW'(uu0_ff);
      uu[1] = NW'(uu1_ff);
      uu[2] = NW'(uu2_ff);
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         SU_SIN_U: begin
            u_ff   <= u_in;
            neg_ff <= ang_val[15];
            if (ang_ff == 2'd0) begin
               quo_ff <= {cfg.focal, 16'd0};
               rem_ff <= '0;
            end
         end
         SU_SIN_U2: u2_ff <= mq[16:0];
         SU_SIN_R1: r_ff  <= SIN_B - mq[16:0];
         SU_SIN_R2: r_ff  <= SIN_A - mq[16:0];
         SU_SIN_S:  sin_ff[ang_ff] <= neg_ff ? -s_mag : s_mag;
         SU_DIV: begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[38:0], ge};
         end
         SU_MUL: begin
            unique case (cnt_ff[3:0])
               4'd0: up0_ff <= -19'(mq);
               4'd1: up2_ff <= 19'(mq);
               4'd2: fw0_ff <= 19'(mq);
               4'd3: fw2_ff <= -19'(mq);
               4'd4: rr0_ff <= 26'(mq);
               4'd5: rr2_ff <= 26'(mq);
               4'd6: uu0_ff <= 26'(mq);
               4'd7: uu1_ff <= 26'(mq);
               4'd8: uu2_ff <= 26'(mq);
               default: ;
            endcase
         end
         SU_NORM: begin
            for (int j = 0; j < 3; j++) begin
               planes_ff[0][j] <= fw[j] + rr[j];
               planes_ff[1][j] <= fw[j] - rr[j];
               planes_ff[2][j] <= fw[j] + uu[j];
               planes_ff[3][j] <= fw[j] - uu[j];
               planes_ff[4][j] <= fw[j];
               planes_ff[5][j] <= -fw[j];
            end
         end
         default: ;
      endcase
   end

   assign planes = planes_ff;

endmodule

@@ design/frustum_box_culling.sv @@
`timescale 1ns / 1ps
// An accepted box passes the d1, pl/ph, p3 and cull registers into rsp_visible.
// Throughput: one box per clock while plane set-up is not busy, set by the five-stage plane test pipeline.
// Plane set-up runs after reset and after every register write
// (4 sines x 5 steps, 40 divider steps, 9 multiplies, 1 combine) with busy high.
// Reset is synchronous: registers take their reset values, the pipeline empties
// and plane set-up starts. The receiver cannot stall: results leave on rsp_valid.
module frustum_box_culling import fbc_pkg::*; #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_box_min_x,
   input  logic signed [31:0] req_box_min_y,
   input  logic signed [31:0] req_box_min_z,
   input  logic signed [31:0] req_box_max_x,
   input  logic signed [31:0] req_box_max_y,
   input  logic signed [31:0] req_box_max_z,
   output logic               rsp_valid,
   output logic               rsp_visible,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   // Distance sums are exact in Q(16 + COORD_FRAC_BITS); constants rounded to nearest.
   localparam int     K      = 16 + COORD_FRAC_BITS;
   localparam longint ONE    = longint'(1) <<< K;
   localparam longint NEAR_D = (ONE + 5) / 10;
   localparam longint FAR_D  = ONE * 1000;
   localparam longint EPS    = (ONE + 5000) / 10000;

   logic signed [31:0] cam_x_ff, cam_y_ff, cam_z_ff;
   logic [15:0] yaw_ff, pitch_ff;
   logic [23:0] aspect_ff, focal_ff;

   logic          setup_busy;
   logic          csr_wr;
   logic          accept;
   setup_cfg_type setup_cfg;
   planes_type    planes;

   logic signed [31:0] lo [3];
   logic signed [31:0] hi [3];
   logic signed [31:0] cam [3];

   // pipeline: corner minus camera, partial products, axis products, plane flags
   logic signed [32:0] d1_ff [6][3];
   logic signed [32:0] d1_in [6][3];
   logic signed [43:0] pl_ff [6][3];
   logic signed [43:0] ph_ff [6][3];
   logic signed [63:0] p3_ff [6][3];
   logic signed [63:0] p3_in [6][3];
   logic signed [63:0] cst [6];
   logic [5:0] cull_ff, cull_in;
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff, rsp_visible_ff;

   assign csr_ready = !setup_busy;
   assign busy      = setup_busy;
   assign csr_wr    = csr_valid && csr_ready;
   assign accept    = start && !busy;

   // Hold the registers; any write restarts the plane set-up.
   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff  <= '0;
         cam_y_ff  <= '0;
         cam_z_ff  <= '0;
         yaw_ff    <= '0;
         pitch_ff  <= '0;
         aspect_ff <= 24'd65536;
         focal_ff  <= 24'd65536;
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_CAM_X:  cam_x_ff  <= csr_data;
            REG_CAM_Y:  cam_y_ff  <= csr_data;
            REG_CAM_Z:  cam_z_ff  <= csr_data;
            REG_YAW:    yaw_ff    <= csr_data[15:0];
            REG_PITCH:  pitch_ff  <= csr_data[15:0];
            REG_ASPECT: aspect_ff <= csr_data[23:0];
            REG_FOCAL:  focal_ff  <= csr_data[23:0];
            default: ;  // index beyond the register list: drop
         endcase
      end
   end

   assign setup_cfg = '{yaw: yaw_ff, pitch: pitch_ff, aspect: aspect_ff, focal: focal_ff};

   fbc_setup u_setup (
      .clock  (clock),
      .reset  (reset),
      .kick   (csr_wr),
      .cfg    (setup_cfg),
      .busy   (setup_busy),
      .planes (planes)
   );

   always_comb begin
      lo[0]  = req_box_min_x;
      lo[1]  = req_box_min_y;
      lo[2]  = req_box_min_z;
      hi[0]  = req_box_max_x;
      hi[1]  = req_box_max_y;
      hi[2]  = req_box_max_z;
      cam[0] = cam_x_ff;
      cam[1] = cam_y_ff;
      cam[2] = cam_z_ff;
      for (int i = 0; i < 6; i++) begin
         cst[i] = '0;
      end
      cst[4] = -NEAR_D;
      cst[5] = FAR_D;
   end

   // Stage 1: pick the corner furthest along each normal, offset by the camera.
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         for (int j = 0; j < 3; j++) begin
            d1_in[i][j] = (planes[i][j] >= 0) ? 33'(hi[j]) - 33'(cam[j])
                                              : 33'(lo[j]) - 33'(cam[j]);
         end
      end
   end

   // Stage 3: join the partial products; fold the near/far offset into the x term.
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         for (int j = 0; j < 3; j++) begin
            p3_in[i][j] = (64'(ph_ff[i][j]) <<< 16) + 64'(pl_ff[i][j]);
         end
         p3_in[i][0] = p3_in[i][0] + cst[i];
      end
   end

   // Stage 4: total each plane and flag it when it falls below -eps.
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         cull_in[i] = (p3_ff[i][0] + p3_ff[i][1] + p3_ff[i][2]) < -EPS;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 6; i++) begin
         for (int j = 0; j < 3; j++) begin
            d1_ff[i][j] <= d1_in[i][j];
            // Stage 2: split the 33-bit offset so each multiply stays narrow.
            pl_ff[i][j] <= 44'(planes[i][j]) * 44'($signed({1'b0, d1_ff[i][j][15:0]}));
            ph_ff[i][j] <= 44'(planes[i][j]) * 44'($signed(d1_ff[i][j][32:16]));
            p3_ff[i][j] <= p3_in[i][j];
         end
      end
      cull_ff        <= cull_in;
      rsp_visible_ff <= !(|cull_ff);
   end

   // Advance the valid bits alongside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= accept;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         rsp_valid_ff <= v4_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_visible = rsp_visible_ff;

endmodule

@@ design/fbc_checker.sv @@
`timescale 1ns / 1ps
module fbc_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic csr_valid,
   input logic csr_ready,
   input logic rsp_valid
);

   a_item_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_valid)
      else $error("accepted item gave no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##5 !rsp_valid)
      else $error("result without an accepted item");

   a_write_setup: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> busy)
      else $error("register write did not start plane set-up");

   a_reset_setup: assert property (@(posedge clock)
      $fell(reset) |-> busy)
      else $error("plane set-up not running after reset");

endmodule

bind frustum_box_culling fbc_checker u_fbc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .rsp_valid (rsp_valid)
);
